// ===== sv/wmrq_pkg.sv =====
package wmrq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 16;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int IDX_W        = POS_W + 1;
    localparam int LVL_W        = $clog2(VALUE_BITS);
    localparam int FIFO_DEPTH   = 2;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_EQUAL  = 3'd1;
    localparam logic [2:0] OP_LESS   = 3'd2;
    localparam logic [2:0] OP_RANGE  = 3'd3;
    localparam logic [2:0] OP_KTH    = 3'd4;
    localparam logic [2:0] OP_SELECT = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
        logic [16:0] upper_value;
        logic [10:0] left;
        logic [10:0] right;
        logic [9:0]  k_index;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] answer;
        logic [1:0]  status;
    } t_out_item;

endpackage

// ===== sv/wavelet_matrix_range_query.sv =====
// Wavelet matrix range-query engine.
// Input channel (i_in_valid / o_in_stall / i_in_item) takes loads and queries;
// a transaction is taken when valid is high and stall is low. Output channel
// (o_out_valid / i_out_stall / o_out_item) returns one answer per query and
// nothing for a load or an unknown opcode.
// A two-entry queue sits in front of the engine, so up to two transactions are
// taken while the engine is busy or its result waits on a stalled receiver;
// a held result stays in the output register until taken.
// The load marked last builds all 16 levels, each in two passes over the n
// stored values through the single value-buffer read port.
// Count, range-count and k-th queries walk 16 levels, with both rank reads of
// a level in the same cycle from the dual-read prefix memory; count in range
// walks twice unless its upper bound is 65536 or more. Select runs two such
// walks and then a binary search per level.
// Reset empties the queue and the output register and marks the matrix as
// not built; queries before a build answer with the not-built status.
module wavelet_matrix_range_query (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wmrq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wmrq_pkg::t_out_item o_out_item
);
    import wmrq_pkg::*;

    logic     w_cmd_valid;
    t_in_item w_cmd;
    logic     w_cmd_pop;

    wmrq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    wmrq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/wmrq_front.sv =====
module wmrq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wmrq_pkg::t_in_item i_in_item,
    output logic               o_cmd_valid,
    output wmrq_pkg::t_in_item o_cmd,
    input  logic               i_cmd_pop
);
    import wmrq_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_in_item               r_q [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       r_rp;
    logic [PTR_W:0]         r_fill;
    logic                   w_push;
    logic                   w_pop;

    assign o_in_stall  = (r_fill == (PTR_W+1)'(FIFO_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rp];
    // drop unknown opcodes here; they never produce a result
    assign w_push = i_in_valid && !o_in_stall && (i_in_item.op <= OP_SELECT);
    assign w_pop  = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_in_item;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

endmodule

// ===== sv/wmrq_engine.sv =====
module wmrq_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  wmrq_pkg::t_in_item  i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wmrq_pkg::t_out_item o_out_item
);
    import wmrq_pkg::*;

    localparam int VA_W = POS_W + 1;
    localparam int PA_W = LVL_W + IDX_W;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(VALUE_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BINIT, S_B1RD, S_B1WR, S_B2RD, S_B2WR,
        S_WRD, S_WUP, S_WEND, S_LSET, S_LRD, S_LUP, S_DONE
    } t_state;
    typedef enum logic [1:0] {W_EQ, W_LESS, W_KTH} t_walk;
    typedef enum logic [1:0] {P_MAIN, P_RANGE2, P_SEL1, P_SEL2} t_phase;

    t_state                 r_state;
    t_walk                  r_walk;
    t_phase                 r_phase;
    logic [IDX_W-1:0]       r_cnt;
    logic                   r_built;
    logic [IDX_W-1:0]       r_zt [VALUE_BITS];
    logic [2:0]             r_op;
    logic [15:0]            r_val;
    logic [16:0]            r_key;
    logic [IDX_W-1:0]       r_k;
    logic [IDX_W-1:0]       r_left;
    logic [IDX_W-1:0]       r_right;
    logic [IDX_W-1:0]       r_l;
    logic [IDX_W-1:0]       r_r;
    logic [LVL_W-1:0]       r_b;
    logic [15:0]            r_acc;
    logic [IDX_W-1:0]       r_hi;
    logic [IDX_W-1:0]       r_c1;
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_j;
    logic [IDX_W-1:0]       r_lo;
    logic [IDX_W-1:0]       r_hs;
    logic [IDX_W-1:0]       r_i;
    logic [IDX_W-1:0]       r_p;
    logic [IDX_W-1:0]       r_ones;
    logic [15:0]            r_ans;
    logic [1:0]             r_st;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [VALUE_BITS-1:0]  r_vbuf [2*MAX_ELEMENTS];
    logic [VALUE_BITS-1:0]  r_vq;
    logic [IDX_W-1:0]       r_pfx [VALUE_BITS*(2**IDX_W)];
    logic [IDX_W-1:0]       r_pa_q;
    logic [IDX_W-1:0]       r_pb_q;

    logic [IDX_W-1:0]       w_eff;
    logic                   w_full;
    logic                   w_vbit;
    logic [IDX_W-1:0]       w_mid;
    logic [IDX_W-1:0]       w_mid1;
    logic [IDX_W-1:0]       w_cnt0;
    logic                   w_d;
    logic [IDX_W-1:0]       w_lc;
    logic [IDX_W-1:0]       w_rc;
    logic [IDX_W-1:0]       w_add;
    logic [IDX_W-1:0]       w_rl;
    logic                   w_ld;
    logic [IDX_W-1:0]       w_lcnt;
    logic [IDX_W:0]         w_occ;
    logic [IDX_W-1:0]       w_cmd_span;
    logic                   w_out_free;
    logic                   vb_we;
    logic [VA_W-1:0]        vb_wa;
    logic [VALUE_BITS-1:0]  vb_wd;
    logic                   pf_we;
    logic [PA_W-1:0]        pf_wa;
    logic [IDX_W-1:0]       pf_wd;
    logic [PA_W-1:0]        pa_ra;
    logic [PA_W-1:0]        pb_ra;

    t_state                 n_state;
    logic [1:0]             n_st;
    logic [15:0]            n_ans;
    t_walk                  n_walk;
    logic [16:0]            n_key;
    t_phase                 n_phase;
    logic [IDX_W-1:0]       n_l;
    logic [IDX_W-1:0]       n_r;
    logic [IDX_W-1:0]       n_hi;

    assign w_eff      = r_built ? '0 : r_cnt;
    assign w_full     = (w_eff == IDX_W'(MAX_ELEMENTS));
    assign w_vbit     = r_vq[~r_b];
    assign w_mid      = r_lo + ((r_hs - r_lo) >> 1);
    assign w_mid1     = w_mid + 1'b1;
    assign w_cnt0     = (r_r - r_pb_q) - (r_l - r_pa_q);
    assign w_d        = (r_walk == W_KTH) ? (r_k >= w_cnt0) : r_key[~r_b];
    assign w_lc       = w_d ? r_pa_q : (r_l - r_pa_q);
    assign w_rc       = w_d ? r_pb_q : (r_r - r_pb_q);
    assign w_add      = w_d ? r_zt[r_b] : '0;
    assign w_rl       = r_r - r_l;
    assign w_ld       = r_val[~r_b];
    assign w_lcnt     = w_ld ? r_pa_q : (w_mid1 - r_pa_q);
    assign w_occ      = {1'b0, r_k} + {1'b0, r_c1};
    assign w_cmd_span = i_cmd.right - i_cmd.left;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // classify the command at the head of the queue
    always_comb begin
        n_state = S_DONE;
        n_st    = ST_OK;
        n_ans   = '0;
        n_walk  = W_EQ;
        n_key   = {1'b0, i_cmd.value};
        n_phase = P_MAIN;
        n_l     = i_cmd.left;
        n_r     = i_cmd.right;
        n_hi    = w_cmd_span;
        if (i_cmd.op == OP_LOAD) begin
            n_state = i_cmd.last ? S_BINIT : S_IDLE;
        end else if (!r_built) begin
            n_st = ST_UNBUILT;
        end else if (i_cmd.op == OP_SELECT) begin
            if (i_cmd.left > r_cnt) begin
                n_st = ST_RANGE;
            end else begin
                n_l     = '0;
                n_r     = i_cmd.left;
                n_phase = P_SEL1;
                n_state = S_WRD;
            end
        end else if (i_cmd.right > r_cnt || i_cmd.left > i_cmd.right) begin
            n_st = ST_RANGE;
        end else begin
            case (i_cmd.op)
                OP_EQUAL: begin
                    n_state = S_WRD;
                end
                OP_LESS: begin
                    if (i_cmd.upper_value[16]) begin
                        n_ans = 16'(w_cmd_span);
                    end else begin
                        n_walk  = W_LESS;
                        n_key   = i_cmd.upper_value;
                        n_state = S_WRD;
                    end
                end
                OP_RANGE: begin
                    n_walk  = W_LESS;
                    n_state = S_WRD;
                    if (i_cmd.upper_value[16]) begin
                        n_phase = P_RANGE2;
                    end else begin
                        n_key = i_cmd.upper_value;
                    end
                end
                OP_KTH: begin
                    if ({1'b0, i_cmd.k_index} >= w_cmd_span) begin
                        n_st = ST_RANGE;
                    end else begin
                        n_walk  = W_KTH;
                        n_state = S_WRD;
                    end
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_comb begin
        vb_we = 1'b0;
        vb_wa = {1'b0, w_eff[POS_W-1:0]};
        vb_wd = i_cmd.value;
        pf_we = 1'b0;
        pf_wa = {r_b, IDX_W'(r_i + 1'b1)};
        pf_wd = r_ones + IDX_W'(w_vbit);
        case (r_state)
            S_IDLE: begin
                vb_we = i_cmd_valid && (i_cmd.op == OP_LOAD) && !w_full;
            end
            S_BINIT: begin
                pf_we = 1'b1;
                pf_wa = {r_b, {IDX_W{1'b0}}};
                pf_wd = '0;
            end
            S_B1WR: begin
                pf_we = 1'b1;
                vb_we = !w_vbit;
                vb_wa = {~r_b[0], r_p[POS_W-1:0]};
                vb_wd = r_vq;
            end
            S_B2WR: begin
                vb_we = w_vbit;
                vb_wa = {~r_b[0], r_p[POS_W-1:0]};
                vb_wd = r_vq;
            end
            default: begin
            end
        endcase
        pa_ra = (r_state == S_LRD) ? {r_b, w_mid1} : {r_b, r_l};
        pb_ra = {r_b, r_r};
    end

    always_ff @(posedge i_clk) begin
        if (vb_we) begin
            r_vbuf[vb_wa] <= vb_wd;
        end
        r_vq <= r_vbuf[{r_b[0], r_i[POS_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            r_pfx[pf_wa] <= pf_wd;
        end
        r_pa_q <= r_pfx[pa_ra];
        r_pb_q <= r_pfx[pb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op    <= i_cmd.op;
                        r_val   <= i_cmd.value;
                        r_left  <= i_cmd.left;
                        r_right <= i_cmd.right;
                        r_k     <= {1'b0, i_cmd.k_index};
                        r_l     <= n_l;
                        r_r     <= n_r;
                        r_acc   <= '0;
                        r_b     <= '0;
                        r_phase <= n_phase;
                        r_ans   <= n_ans;
                        r_st    <= n_st;
                        r_walk  <= n_walk;
                        r_key   <= n_key;
                        r_hi    <= n_hi;
                        r_state <= n_state;
                        if (i_cmd.op == OP_LOAD) begin
                            r_built <= 1'b0;
                            r_cnt   <= w_full ? w_eff : w_eff + 1'b1;
                        end
                    end
                end
                S_BINIT: begin
                    r_p     <= '0;
                    r_i     <= '0;
                    r_ones  <= '0;
                    r_state <= S_B1RD;
                end
                S_B1RD: begin
                    if (r_i == r_cnt) begin
                        r_zt[r_b] <= r_p;
                        r_i       <= '0;
                        r_state   <= S_B2RD;
                    end else begin
                        r_state <= S_B1WR;
                    end
                end
                S_B1WR: begin
                    r_ones <= r_ones + IDX_W'(w_vbit);
                    if (!w_vbit) begin
                        r_p <= r_p + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_B1RD;
                end
                S_B2RD: begin
                    if (r_i == r_cnt) begin
                        if (r_b == LAST_LVL) begin
                            r_built <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_b     <= r_b + 1'b1;
                            r_state <= S_BINIT;
                        end
                    end else begin
                        r_state <= S_B2WR;
                    end
                end
                S_B2WR: begin
                    if (w_vbit) begin
                        r_p <= r_p + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_B2RD;
                end
                S_WRD: begin
                    r_state <= S_WUP;
                end
                S_WUP: begin
                    r_l <= w_lc + w_add;
                    r_r <= w_rc + w_add;
                    if (r_walk == W_LESS && w_d) begin
                        r_acc <= r_acc + 16'(w_rl - (w_rc - w_lc));
                    end
                    if (r_walk == W_KTH) begin
                        r_acc <= {r_acc[14:0], w_d};
                        if (w_d) begin
                            r_k <= r_k - w_cnt0;
                        end
                    end
                    if (r_b == LAST_LVL) begin
                        r_state <= S_WEND;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_WRD;
                    end
                end
                S_WEND: begin
                    case (r_op)
                        OP_EQUAL: begin
                            r_ans   <= 16'(w_rl);
                            r_state <= S_DONE;
                        end
                        OP_RANGE: begin
                            if (r_phase == P_MAIN) begin
                                r_hi    <= IDX_W'(r_acc);
                                r_key   <= {1'b0, r_val};
                                r_l     <= r_left;
                                r_r     <= r_right;
                                r_b     <= '0;
                                r_acc   <= '0;
                                r_phase <= P_RANGE2;
                                r_state <= S_WRD;
                            end else begin
                                if (r_hi > IDX_W'(r_acc)) begin
                                    r_ans <= 16'(r_hi - IDX_W'(r_acc));
                                end
                                r_state <= S_DONE;
                            end
                        end
                        OP_SELECT: begin
                            if (r_phase == P_SEL1) begin
                                r_c1    <= w_rl;
                                r_l     <= '0;
                                r_r     <= r_cnt;
                                r_b     <= '0;
                                r_phase <= P_SEL2;
                                r_state <= S_WRD;
                            end else if (w_occ >= {1'b0, w_rl}) begin
                                r_st    <= ST_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                // first matching slot at the bottom, then climb back up
                                r_pos   <= r_l + w_occ[IDX_W-1:0];
                                r_b     <= LAST_LVL;
                                r_state <= S_LSET;
                            end
                        end
                        default: begin
                            r_ans   <= r_acc;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_LSET: begin
                    r_j     <= w_ld ? r_pos - r_zt[r_b] : r_pos;
                    r_lo    <= '0;
                    r_hs    <= r_cnt - 1'b1;
                    r_state <= S_LRD;
                end
                S_LRD: begin
                    if (r_lo >= r_hs) begin
                        if (r_b == '0) begin
                            r_ans   <= 16'(r_lo);
                            r_state <= S_DONE;
                        end else begin
                            r_pos   <= r_lo;
                            r_b     <= r_b - 1'b1;
                            r_state <= S_LSET;
                        end
                    end else begin
                        r_state <= S_LUP;
                    end
                end
                S_LUP: begin
                    if (w_lcnt > r_j) begin
                        r_hs <= w_mid;
                    end else begin
                        r_lo <= w_mid1;
                    end
                    r_state <= S_LRD;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.answer <= r_ans;
                        r_out.status <= r_st;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= IDX_W'(MAX_ELEMENTS))
        else $error("element count exceeds capacity");

    a_built_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (r_cnt != '0))
        else $error("built matrix with no elements");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WUP) |-> (r_l <= r_r))
        else $error("walk range inverted");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LUP) |-> (r_lo < r_hs))
        else $error("search bounds crossed");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state != S_IDLE) || (r_op == OP_LOAD))
        else $error("query popped without starting");

endmodule

// ===== test/wmrq_checker.sv =====
`timescale 1ns / 1ps

module wmrq_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  wmrq_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  wmrq_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import wmrq_pkg::*;

    logic [15:0] loaded_seq[$];
    bit          matrix_built;
    t_out_item   expected_answers[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        matrix_built = 0;
    end

    function automatic int count_equal_in(int l, int r, logic [15:0] v);
        int c;
        c = 0;
        for (int i = l; i < r; i++) if (loaded_seq[i] == v) c++;
        return c;
    endfunction

    function automatic int count_below_in(int l, int r, logic [16:0] ub);
        int c;
        c = 0;
        for (int i = l; i < r; i++) if ({1'b0, loaded_seq[i]} < ub) c++;
        return c;
    endfunction

    function automatic t_out_item answer_query(t_in_item q);
        t_out_item   res;
        int          n, l, r, k, occ, total, hi, lo;
        logic [15:0] window[$];
        n = loaded_seq.size();
        l = q.left;
        r = q.right;
        k = q.k_index;
        res = '{answer: '0, status: ST_OK};
        if (!matrix_built) begin
            res.status = ST_UNBUILT;
        end else if (q.op == OP_SELECT) begin
            if (l > n) begin
                res.status = ST_RANGE;
            end else begin
                occ   = k + count_equal_in(0, l, q.value);
                total = count_equal_in(0, n, q.value);
                if (occ >= total) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (loaded_seq[i] == q.value) begin
                            if (occ == 0) begin
                                res.answer = 16'(i);
                                break;
                            end
                            occ--;
                        end
                    end
                end
            end
        end else if (r > n || l > r) begin
            res.status = ST_RANGE;
        end else if (q.op == OP_EQUAL) begin
            res.answer = 16'(count_equal_in(l, r, q.value));
        end else if (q.op == OP_LESS) begin
            res.answer = 16'(count_below_in(l, r, q.upper_value));
        end else if (q.op == OP_RANGE) begin
            hi = count_below_in(l, r, q.upper_value);
            lo = count_below_in(l, r, {1'b0, q.value});
            res.answer = hi > lo ? 16'(hi - lo) : 16'd0;
        end else if (k >= r - l) begin
            res.status = ST_RANGE;
        end else begin
            for (int i = l; i < r; i++) window = {window, loaded_seq[i]};
            window.sort();
            res.answer = window[k];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.op == OP_LOAD) begin
                    if (matrix_built) begin
                        loaded_seq.delete();
                        matrix_built = 0;
                    end
                    if (loaded_seq.size() < MAX_ELEMENTS)
                        loaded_seq = {loaded_seq, i_in_item.value};
                    if (i_in_item.last) matrix_built = 1;
                end else if (i_in_item.op <= OP_SELECT) begin
                    expected_answers = {expected_answers, answer_query(i_in_item)};
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result, answer", -1, i_out_item.answer);
                end else begin
                    want = expected_answers.pop_front();
                    if (want.answer != i_out_item.answer)
                        report_mismatch("answer", want.answer, i_out_item.answer);
                    if (want.status != i_out_item.status)
                        report_mismatch("status", want.status, i_out_item.status);
                end
            end
            o_pending = expected_answers.size();
        end
    end

endmodule

// ===== test/tb_wavelet_matrix_range_query.sv =====
`timescale 1ns / 1ps

module tb_wavelet_matrix_range_query;
    import wmrq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_item o_out_item;
    int        fail_count, pending;
    int        cycle_count = 0;
    bit        hold_req = 0, hold_done = 0;
    int        calm_left = 0;
    int        item_count = 0;
    logic [15:0] tb_vals[$];
    bit          tb_built = 0;

    wavelet_matrix_range_query u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    wmrq_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_item(o_out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("wavelet_matrix_range_query: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int r;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1;
                repeat (400) @(posedge i_clk);
                hold_done = 1;
                i_out_stall <= 0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall <= 0;
            end else if (r < 2) begin
                calm_left = $urandom_range(50, 300);
                i_out_stall <= 0;
            end else if (r < 55) begin
                i_out_stall <= 0;
            end else if (r < 95) begin
                i_out_stall <= 1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_stall <= 0;
            end else begin
                i_out_stall <= 1;
                repeat ($urandom_range(15, 60)) @(posedge i_clk);
                i_out_stall <= 0;
            end
        end
    end

    function automatic t_in_item mk(logic [2:0] op, logic [15:0] v, logic [16:0] ub,
                                    logic [10:0] l, logic [10:0] r, logic [9:0] k,
                                    logic last);
        return '{op: op, value: v, upper_value: ub, left: l, right: r, k_index: k,
                 last: last};
    endfunction

    task automatic send(t_in_item it);
        int r, gap;
        i_in_valid <= 1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        item_count++;
        if (it.op == OP_LOAD) begin
            if (tb_built) begin
                tb_vals.delete();
                tb_built = 0;
            end
            if (tb_vals.size() < MAX_ELEMENTS) tb_vals = {tb_vals, it.value};
            if (it.last) tb_built = 1;
        end
        r = $urandom_range(0, 99);
        gap = (calm_left > 0 || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 40);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic load_set(int n, bit few_symbols, bit mark_last);
        for (int i = 0; i < n; i++)
            send(mk(OP_LOAD, few_symbols ? 16'($urandom_range(0, 5)) : 16'($urandom),
                    17'($urandom), 11'($urandom), 11'($urandom), 10'($urandom),
                    mark_last && i == n - 1));
    endtask

    function automatic t_in_item rand_query();
        int          n, l, r, ch;
        logic [2:0]  op;
        logic [15:0] v;
        logic [16:0] ub;
        logic [9:0]  k;
        n  = tb_vals.size();
        op = 3'($urandom_range(OP_EQUAL, OP_SELECT));
        ch = $urandom_range(0, 99);
        if (ch < 85) begin
            r = $urandom_range(0, n);
            l = $urandom_range(0, r);
        end else begin
            r = $urandom_range(0, 2047);
            l = $urandom_range(0, 2047);
        end
        v  = (n > 0 && $urandom_range(0, 9) < 6) ? tb_vals[$urandom_range(0, n - 1)]
                                                  : 16'($urandom);
        ub = ($urandom_range(0, 9) < 5) ? 17'({1'b0, v} + $urandom_range(0, 3))
                                        : 17'($urandom_range(0, 65536));
        if (ch < 80) k = 10'($urandom_range(0, (r > l) ? r - l : 2));
        else k = 10'($urandom);
        if (op == OP_SELECT && ch < 60) k = 10'($urandom_range(0, 3));
        return mk(op, v, ub, 11'(l), 11'(r), k, 1'($urandom));
    endfunction

    initial begin
        int n, seq_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send(mk(OP_EQUAL, 0, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd0, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'hffff, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd5, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd5, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'h8000, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd5, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd1, 0, 0, 0, 0, 1));
        send(mk(OP_EQUAL, 16'd5, 0, 0, 7, 0, 0));
        send(mk(OP_LESS, 0, 17'h10000, 0, 7, 0, 0));
        send(mk(OP_LESS, 0, 17'd0, 1, 6, 0, 0));
        send(mk(OP_RANGE, 16'd5, 17'h8001, 0, 7, 0, 0));
        send(mk(OP_RANGE, 16'd100, 17'd3, 0, 7, 0, 0));
        send(mk(OP_KTH, 0, 0, 0, 7, 10'd0, 0));
        send(mk(OP_KTH, 0, 0, 0, 7, 10'd6, 0));
        send(mk(OP_KTH, 0, 0, 2, 5, 10'd3, 0));
        send(mk(OP_SELECT, 16'd5, 0, 11'd3, 0, 10'd0, 0));
        send(mk(OP_SELECT, 16'd5, 0, 11'd0, 0, 10'd3, 0));
        send(mk(OP_SELECT, 16'd5, 0, 11'd8, 0, 10'd0, 0));
        send(mk(OP_SELECT, 16'd5, 0, 11'd7, 0, 10'd0, 0));
        send(mk(OP_EQUAL, 16'd5, 0, 0, 11'd8, 0, 0));
        send(mk(OP_EQUAL, 16'd5, 0, 11'd5, 11'd3, 0, 0));
        send(mk(3'd6, 0, 0, 0, 0, 0, 0));
        send(mk(3'd7, 0, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 16'd9, 0, 0, 0, 0, 0));
        send(mk(OP_LESS, 0, 17'd10, 0, 1, 0, 0));
        send(mk(OP_LOAD, 16'd9, 0, 0, 0, 0, 1));

        // random sequences: load a set, build, query it
        seq_no = 0;
        while (item_count < 500 || seq_no < 8) begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(100, 200);
            else n = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) begin
                // broken sequence: queries hit an unbuilt matrix
                load_set($urandom_range(1, 5), 1, 0);
                repeat (3) send(rand_query());
            end
            load_set(n, $urandom_range(0, 1), 1);
            if (seq_no == 2) hold_req = 1;
            repeat ((seq_no == 2) ? 20 : $urandom_range(3, 15)) begin
                if ($urandom_range(0, 19) == 0)
                    send(mk(3'($urandom_range(6, 7)), 16'($urandom), 17'($urandom),
                            11'($urandom), 11'($urandom), 10'($urandom), 1'($urandom)));
                else
                    send(rand_query());
            end
            if (seq_no == 3 || $urandom_range(0, 7) == 0) drain();
            seq_no++;
        end
        send(rand_query());
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("wavelet_matrix_range_query: match");
        else
            $display("wavelet_matrix_range_query: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wmrq_pkg.sv
sv/wmrq_front.sv
sv/wmrq_engine.sv
sv/wavelet_matrix_range_query.sv
test/wmrq_checker.sv
test/tb_wavelet_matrix_range_query.sv
